>>> rtl/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg
// Shared types, constants and helpers of the radix integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

    // Value and field widths
    localparam int VALUE_BITS = 64;
    localparam int MAG_W      = VALUE_BITS - 1;
    localparam int OUT_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 6;
    localparam int PROD_W     = MAG_W + RADIX_W;

    // Largest magnitude, and the same zero-extended to the result width
    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_LIMIT = {{(OUT_W - MAG_W){1'b0}}, MAG_LIMIT};

    // Radix codes
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

    // Digit code for a character that is no digit in any radix
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_LO_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified character word
    typedef struct packed {
        logic [RADIX_W-1:0] digit;
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               last;
    } rip_class_t;

    function automatic logic radix_valid(input logic [RADIX_W-1:0] r);
        return (r >= RADIX_MIN) && (r <= RADIX_MAX);
    endfunction

endpackage

`default_nettype wire

>>> rtl/rip_front.sv
// ----------------------------------------------------------------------------
// rip_front
// Classifies one input character: digit value, whitespace, sign, zero, 'x'.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_front import rip_pkg::*; (
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              last_char,
    output rip_class_t             cls
);

    logic [CHAR_W-1:0] diff_num;
    logic [CHAR_W-1:0] diff_up;
    logic [CHAR_W-1:0] diff_lo;

    assign diff_num = char_code - CHAR_ZERO;
    assign diff_up  = char_code - CHAR_UP_A + LETTER_BASE;
    assign diff_lo  = char_code - CHAR_LO_A + LETTER_BASE;

    // Map the character to its digit value
    always_comb begin
        cls = '0;
        priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
            cls.digit = diff_num[RADIX_W-1:0];
        end else if (char_code >= CHAR_UP_A && char_code <= CHAR_UP_Z) begin
            cls.digit = diff_up[RADIX_W-1:0];
        end else if (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z) begin
            cls.digit = diff_lo[RADIX_W-1:0];
        end else begin
            cls.digit = DIGIT_NONE;
        end
        cls.is_space = (char_code == CHAR_SPACE) ||
                       (char_code >= CHAR_TAB && char_code <= CHAR_CR);
        cls.is_plus  = (char_code == CHAR_PLUS);
        cls.is_minus = (char_code == CHAR_MINUS);
        cls.is_zero  = (char_code == CHAR_ZERO);
        cls.is_x     = (char_code == CHAR_LO_X) || (char_code == CHAR_UP_X);
        cls.last     = last_char;
    end

endmodule

`default_nettype wire

>>> rtl/rip_queue.sv
// ----------------------------------------------------------------------------
// rip_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_queue import rip_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  rip_class_t      push_word,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output rip_class_t      head_word
);

    rip_class_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rip_back.sv
// ----------------------------------------------------------------------------
// rip_back
// Parse engine: phase tracking, radix selection, digit multiply-add with
// saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_back import rip_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [RADIX_W-1:0] radix_setting,
    input  wire logic               q_not_empty,
    input  rip_class_t              q_word,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [OUT_W-1:0]        m_parsed_value,
    output logic                    m_not_a_number,
    output logic                    m_saturated
);

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    phase_t              phase_reg,  phase_next;
    phase_t              phase_sel;
    logic [RADIX_W-1:0]  radix_reg,  radix_next;
    logic                neg_reg,    neg_next;
    logic [MAG_W-1:0]    mag_reg,    mag_next;
    logic                seen_reg,   seen_next;
    logic                ovf_reg,    ovf_next;

    logic                m_valid_reg;
    logic [OUT_W-1:0]    value_reg,  value_next;
    logic                nan_reg,    nan_next;
    logic                sat_reg,    sat_next;

    logic                sign_done;
    logic                take;
    logic                digit_ok;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   sum;
    logic                sum_over;
    logic [OUT_W-1:0]    mag_ext;

    // Pop unless a final word would overwrite a result not yet taken
    assign q_pop = q_not_empty && !(q_word.last && m_valid_reg && !m_ready);

    // Step the phase and choose the radix for this word
    always_comb begin
        phase_sel  = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        sign_done  = 1'b0;
        take       = 1'b0;
        unique case (phase_reg)
            PH_SPACE: begin
                if (!q_word.is_space) begin
                    radix_next = radix_setting;
                    if (q_word.is_plus || q_word.is_minus) begin
                        neg_next  = q_word.is_minus;
                        phase_sel = PH_SIGNED;
                    end else begin
                        sign_done = 1'b1;
                    end
                end
            end
            PH_SIGNED: begin
                sign_done = 1'b1;
            end
            PH_ZERO: begin
                if (q_word.is_x) begin
                    radix_next = RADIX_HEX;
                    phase_sel  = PH_DIGITS;
                end else begin
                    radix_next = RADIX_OCT;
                    take       = 1'b1;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase
        // Detect the base after the sign
        if (sign_done) begin
            if (radix_next == RADIX_AUTO) begin
                if (q_word.is_zero && !q_word.last) begin
                    phase_sel = PH_ZERO;
                end else begin
                    radix_next = RADIX_DEC;
                    take       = 1'b1;
                end
            end else begin
                take = 1'b1;
            end
        end
    end

    // Multiply-add one digit, clamp on overflow
    assign prod     = PROD_W'(mag_reg) * PROD_W'(radix_next);
    assign sum      = prod + PROD_W'(q_word.digit);
    assign sum_over = |sum[PROD_W-1:MAG_W];
    assign digit_ok = radix_valid(radix_next) && (q_word.digit < radix_next);

    always_comb begin
        phase_next = phase_sel;
        mag_next   = mag_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        if (take) begin
            if (!digit_ok) begin
                phase_next = PH_STOP;
            end else begin
                phase_next = PH_DIGITS;
                seen_next  = 1'b1;
                if (!ovf_reg) begin
                    if (sum_over) begin
                        ovf_next = 1'b1;
                        mag_next = MAG_LIMIT;
                    end else begin
                        mag_next = sum[MAG_W-1:0];
                    end
                end
            end
        end
    end

    // Form the result of a finished string
    assign mag_ext = {{(OUT_W - MAG_W){1'b0}}, mag_next};

    always_comb begin
        nan_next   = !seen_next || !radix_valid(radix_next);
        value_next = '0;
        if (!nan_next) begin
            value_next = neg_next ? (OUT_W'(0) - mag_ext) : mag_ext;
        end
        sat_next = !nan_next && ovf_next;
    end

    // Hold parse state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            radix_reg   <= RADIX_AUTO;
            neg_reg     <= 1'b0;
            mag_reg     <= '0;
            seen_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop && q_word.last) begin
                phase_reg   <= PH_SPACE;
                radix_reg   <= RADIX_AUTO;
                neg_reg     <= 1'b0;
                mag_reg     <= '0;
                seen_reg    <= 1'b0;
                ovf_reg     <= 1'b0;
                m_valid_reg <= 1'b1;
                value_reg   <= value_next;
                nan_reg     <= nan_next;
                sat_reg     <= sat_next;
            end else begin
                if (q_pop) begin
                    phase_reg <= phase_next;
                    radix_reg <= radix_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    seen_reg  <= seen_next;
                    ovf_reg   <= ovf_next;
                end
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_parsed_value = value_reg;
    assign m_not_a_number = nan_reg;
    assign m_saturated    = sat_reg;

endmodule

`default_nettype wire

>>> rtl/radix_integer_parser_top.sv
// ----------------------------------------------------------------------------
// radix_integer_parser_top
// Streaming parseInt: ASCII characters in, one signed integer per string out.
// ----------------------------------------------------------------------------
// Takes one character word per cycle, sustained, while the result side keeps
// up; the rate is set by the back engine, which does one multiply-add by the
// radix per cycle. A result is registered: the last character's word is written
// into the four-word queue when accepted, and loads the result register when
// the back engine pops it, which waits while an earlier result is not taken.
// Write cfg_data (radix: 0 auto-detect, 2..36 that base) only while idle; it
// is sampled at the first non-whitespace character of each string. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_parser_top import rip_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [RADIX_W-1:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CHAR_W-1:0]  s_char_code,
    input  wire logic               s_last_char,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [OUT_W-1:0]        m_parsed_value,
    output logic                    m_not_a_number,
    output logic                    m_saturated
);

    logic [RADIX_W-1:0] radix_setting_reg;
    rip_class_t         front_word;
    rip_class_t         head_word;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;

    // Hold the radix register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_setting_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_setting_reg <= cfg_data;
        end
    end

    assign s_ready = !q_full;

    rip_front u_front (
        .char_code (s_char_code),
        .last_char (s_last_char),
        .cls       (front_word)
    );

    rip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_word (front_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    rip_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .radix_setting  (radix_setting_reg),
        .q_not_empty    (q_not_empty),
        .q_word         (head_word),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_not_a_number (m_not_a_number),
        .m_saturated    (m_saturated)
    );

endmodule

`default_nettype wire

>>> rtl/rip_checker.sv
// ----------------------------------------------------------------------------
// rip_checker
// Port-level checks of the radix integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_checker import rip_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [OUT_W-1:0] m_parsed_value,
    input wire logic             m_not_a_number,
    input wire logic             m_saturated
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parsed_value) &&
            $stable(m_not_a_number) && $stable(m_saturated))
        else $error("result changed while stalled");

    // Drop any result at reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Not-a-number carries a zero value and no clamp
    a_nan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_not_a_number |-> (m_parsed_value == '0) && !m_saturated)
        else $error("not-a-number with nonzero value or clamp");

    // A clamped result sits at plus or minus the limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_parsed_value == OUT_LIMIT) || (m_parsed_value == (OUT_W'(0) - OUT_LIMIT)))
        else $error("clamped result off the limit");

endmodule

bind radix_integer_parser_top rip_checker u_rip_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming radix integer parser.
// ----------------------------------------------------------------------------
// Strings go in one character word at a time, and each string ends with the
// last-character flag on its final byte. The bench runs its own parse of every
// accepted word and queues one expected integer per string. Each result word is
// checked against the oldest entry in that queue. The run starts with directed
// strings for the reset radix, auto-detect, fixed bases and invalid bases. It
// then sweeps the radix register through random strings, which are mostly
// well formed and partly noise. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_top;
    import rip_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 6;

    // Radix values outside the useful range
    localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OVER = 6'd37;
    localparam logic [RADIX_W-1:0] RADIX_TOP  = 6'd63;

    localparam logic [6:0] DIGIT_NIL = 7'd127;

    typedef enum logic [2:0] {
        PS_SPACE,
        PS_SIGNED,
        PS_ZERO,
        PS_DIGITS,
        PS_STOP
    } parse_phase_e;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             nan;
        logic             sat;
    } parse_result_t;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [RADIX_W-1:0] cfg_data    = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_char_code = '0;
    logic               s_last_char = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b1;
    logic [OUT_W-1:0]   m_parsed_value;
    logic               m_not_a_number;
    logic               m_saturated;

    // Parser state as the bench sees it
    logic [RADIX_W-1:0] radix_reg;
    parse_phase_e       ps_phase;
    logic [RADIX_W-1:0] ps_radix;
    logic               ps_neg;
    logic [MAG_W-1:0]   ps_mag;
    logic               ps_digit;
    logic               ps_ovf;

    parse_result_t      pending_results[$];
    int                 err_cnt     = 0;
    int                 idle_cycles = 0;
    int                 stall_left  = 0;
    bit                 no_idle     = 1'b0;

    radix_integer_parser_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_not_a_number (m_not_a_number),
        .m_saturated    (m_saturated)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------
    function automatic logic [6:0] digit_of(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 7'(c - CHAR_ZERO);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return 7'(c - CHAR_UP_A + LETTER_BASE);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return 7'(c - CHAR_LO_A + LETTER_BASE);
        return DIGIT_NIL;
    endfunction

    function automatic bit base_ok(input logic [RADIX_W-1:0] r);
        return r >= RADIX_MIN && r <= RADIX_MAX;
    endfunction

    task automatic clear_parse();
        ps_phase = PS_SPACE;
        ps_radix = RADIX_AUTO;
        ps_neg   = 1'b0;
        ps_mag   = '0;
        ps_digit = 1'b0;
        ps_ovf   = 1'b0;
    endtask

    task automatic accumulate_digit(input logic [CHAR_W-1:0] c);
        logic [6:0]  d;
        logic [63:0] bound;
        logic [63:0] next_mag;
        d = digit_of(c);
        // Stop at the first character that is no digit of this base
        if (!base_ok(ps_radix) || d >= ps_radix) begin
            ps_phase = PS_STOP;
            return;
        end
        ps_phase = PS_DIGITS;
        ps_digit = 1'b1;
        if (ps_ovf) return;
        bound = ({1'b0, MAG_LIMIT} - d) / ps_radix;
        if ({1'b0, ps_mag} > bound) begin
            ps_ovf = 1'b1;
            ps_mag = MAG_LIMIT;
        end else begin
            next_mag = {1'b0, ps_mag} * ps_radix + d;
            ps_mag   = next_mag[MAG_W-1:0];
        end
    endtask

    task automatic start_number(input logic [CHAR_W-1:0] c, input logic is_last);
        // Under auto-detect a leading zero may open a hex or octal prefix
        if (ps_radix == RADIX_AUTO) begin
            if (c == CHAR_ZERO && !is_last) begin
                ps_phase = PS_ZERO;
                return;
            end
            ps_radix = RADIX_DEC;
        end
        accumulate_digit(c);
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic is_last);
        parse_result_t res;
        case (ps_phase)
            PS_SPACE: begin
                if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
                    ps_radix = radix_reg;
                    if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        ps_neg   = (c == CHAR_MINUS);
                        ps_phase = PS_SIGNED;
                    end else begin
                        start_number(c, is_last);
                    end
                end
            end
            PS_SIGNED: start_number(c, is_last);
            PS_ZERO: begin
                if (c == CHAR_LO_X || c == CHAR_UP_X) begin
                    ps_radix = RADIX_HEX;
                    ps_phase = PS_DIGITS;
                end else begin
                    ps_radix = RADIX_OCT;
                    accumulate_digit(c);
                end
            end
            PS_DIGITS: accumulate_digit(c);
            default: ;
        endcase
        if (!is_last) return;
        // End of string: one integer out, then start over
        res.nan   = !ps_digit || !base_ok(ps_radix);
        res.value = '0;
        if (!res.nan) res.value = ps_neg ? 64'd0 - {1'b0, ps_mag} : {1'b0, ps_mag};
        res.sat   = !res.nan && ps_ovf;
        pending_results.push_back(res);
        clear_parse();
    endtask

    // Track accepted words and register writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg = RADIX_RESET;
            clear_parse();
        end else begin
            if (cfg_valid && cfg_ready) radix_reg = cfg_data;
            if (s_valid && s_ready) parse_char(s_char_code, s_last_char);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, value", m_parsed_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_parsed_value !== want.value)
                    report_mismatch("parsed_value", m_parsed_value, want.value);
                if (m_not_a_number !== want.nan)
                    report_mismatch("not_a_number", 64'(m_not_a_number), 64'(want.nan));
                if (m_saturated !== want.sat)
                    report_mismatch("saturated", 64'(m_saturated), 64'(want.sat));
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idle and stall timing
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drop m_ready for random stretches
    always @(negedge aclk) begin
        if (stall_left == 0 && $urandom_range(0, 99) < 30) stall_left = pick_gap();
        m_ready = (stall_left == 0);
        if (stall_left != 0) stall_left--;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_char_code = c;
        s_last_char = is_last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_bytes(input logic [CHAR_W-1:0] text[$]);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Drain and settle, then write the radix register
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = r;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random string builder
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] digit_char(input int v);
        if (v < 10) return 8'(CHAR_ZERO + v);
        if ($urandom_range(0, 1)) return 8'(CHAR_UP_A + v - 10);
        return 8'(CHAR_LO_A + v - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] space_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_SPACE : 8'(CHAR_TAB + k);
    endfunction

    task automatic build_text(output logic [CHAR_W-1:0] text[$]);
        int kind;
        int p;
        int n;
        int dr;
        text = {};
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            // Noise: arbitrary bytes
            n = $urandom_range(1, 5);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) text.push_back(space_char());
            p = $urandom_range(0, 99);
            if (p < 25) text.push_back(CHAR_PLUS);
            else if (p < 50) text.push_back(CHAR_MINUS);
            dr = base_ok(radix_reg) ? int'(radix_reg) : int'(RADIX_MAX);
            if (radix_reg == RADIX_AUTO) begin
                p = $urandom_range(0, 99);
                dr = int'(RADIX_DEC);
                if (p < 30) begin
                    text.push_back(CHAR_ZERO);
                    text.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
                    dr = int'(RADIX_HEX);
                end else if (p < 55) begin
                    text.push_back(CHAR_ZERO);
                    dr = int'(RADIX_OCT);
                end
            end
            p = $urandom_range(0, 99);
            if (p < 5) n = 0;
            else if (p < 85) n = $urandom_range(1, 8);
            else n = $urandom_range(9, 24);
            repeat (n) text.push_back(digit_char($urandom_range(0, dr - 1)));
            // Trailing junk ends the digits early or is ignored
            if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
        end
        if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_radix();
        send_text("-0");
        send_text(" 9");
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_auto_detect();
        write_radix(RADIX_AUTO);
        send_text("0x1f");
        send_text("08");
        send_text("0");
        send_text("-017");
    endtask

    task automatic test_fixed_radix();
        write_radix(RADIX_HEX);
        send_text("0x1");
        write_radix(RADIX_MAX);
        send_text("Zz");
        write_radix(RADIX_MIN);
        send_text("12");
    endtask

    task automatic test_invalid_radix();
        write_radix(RADIX_ONE);
        send_text("5");
        write_radix(RADIX_TOP);
        send_text("5");
    endtask

    task automatic test_random_text();
        logic [CHAR_W-1:0]  text[$];
        logic [RADIX_W-1:0] r;
        int                 sent;
        for (int ph = 0; ph < 20; ph++) begin
            case (ph)
                0: r = RADIX_AUTO;
                1: r = RADIX_MIN;
                2: r = RADIX_MAX;
                3: r = RADIX_DEC;
                4: r = RADIX_HEX;
                5: r = RADIX_OCT;
                6: r = RADIX_ONE;
                7: r = RADIX_OVER;
                8: r = RADIX_TOP;
                default: r = ($urandom_range(0, 4) == 0) ? RADIX_AUTO
                           : 6'($urandom_range(RADIX_MIN, RADIX_MAX));
            endcase
            write_radix(r);
            // Every fourth phase runs without gaps or stalls
            no_idle = (ph % 4 == 3);
            sent = 0;
            while (sent < 95) begin
                build_text(text);
                send_bytes(text);
                sent += text.size();
            end
        end
        s_valid = 1'b0;
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_radix();
        test_auto_detect();
        test_fixed_radix();
        test_invalid_radix();
        test_random_text();
        // Wait out the last results
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rip_pkg.sv
rtl/rip_front.sv
rtl/rip_queue.sv
rtl/rip_back.sv
rtl/radix_integer_parser_top.sv
rtl/rip_checker.sv
sim/tb_top.sv
